// ----- rtl/gce_pkg.sv -----
package gce_pkg;

	localparam int AVG_W         = 16;
	localparam int KNOWN_W       = 16;
	localparam int MANT_W        = 24;
	localparam int DF_W          = 21;
	localparam int PROD_W        = MANT_W + DF_W;
	localparam int EXP_W         = 8;
	localparam int WORD_W        = 32;
	localparam int MIN_DIV_W     = 17;
	localparam int VDIV_STEPS    = 32;
	localparam int CDIV_MAX      = 56;
	localparam int GAIN_EXP_BASE = MANT_W + KNOWN_W;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [DF_W-1:0]  DELTA_FACTOR = 21'h123456;
	localparam logic [EXP_W-1:0] EXP_BIAS     = 8'd128;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SAMPLE_COUNT   = 3'd0,
		REG_CAL_MODE       = 3'd1,
		REG_KNOWN_VALUE    = 3'd2,
		REG_COULOMB_OFFSET = 3'd3,
		REG_BOARD_TRIM     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_BRANCH,
		ST_VDIV,
		ST_VDONE,
		ST_CDIV,
		ST_CRND,
		ST_MUL,
		ST_DRND,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic din;
	} div_cmd_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic cbit;
	} mul_cmd_t;

endpackage

// ----- rtl/gauge_calibration_coefficient_engine.sv -----
// Gauge calibration coefficient engine. Each input beat is one poll (counter and raw
// sample); polls are taken even while a result waits on the output. The poll that
// completes a run starts the coefficient pass, during which no poll is taken:
// averaging, then in voltage mode setup, 32 division steps and the result, or in
// current mode setup, division, rounding of the gain, multiplication and delta
// rounding. A zero divisor or a zero known current goes from the setup state straight
// to the output. The output register is loaded from the final state, which is held
// for as long as an earlier result still waits there. The pass uses the shared
// divider, which yields one quotient bit per cycle, and the multiplier by the delta
// factor, which takes one factor bit per cycle.
module gauge_calibration_coefficient_engine import gce_pkg::*; #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// cal_counter[7:0], raw_sample[23:8]
	input  logic [23:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// average_raw[15:0], volt_gain[31:16], gain_word[63:32], delta_word[95:64]
	output logic [95:0]           m_axis_tdata,
	// status[0]
	output logic [0:0]            m_axis_tuser
);

	localparam int CW      = $clog2(MAX_SAMPLES + 1);
	localparam int TW      = (CW > 9) ? CW : 9;
	localparam int SW      = AVG_W + CW;
	localparam int DW      = (CW > MIN_DIV_W) ? CW : MIN_DIV_W;
	localparam int DVW     = (SW > VDIV_STEPS) ? SW : VDIV_STEPS;
	localparam int MAXSTEP = (SW > CDIV_MAX) ? SW : CDIV_MAX;
	localparam int CNTW    = $clog2(MAXSTEP + 1);

	function automatic logic [WORD_W-1:0] pack_word(input logic neg,
		input logic [EXP_W-1:0] ex, input logic [MANT_W-1:0] mant);
		pack_word = {ex + EXP_BIAS, neg, mant[MANT_W-2:0]};
	endfunction

	state_t state_q, state_nx;

	// configuration
	logic [8:0]  sample_count_q;
	logic        cal_mode_q;
	logic [15:0] known_q;
	logic [15:0] coff_q;
	logic [7:0]  btrim_q;

	// accumulation
	logic          seen_q;
	logic [7:0]    last_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] taken_q;

	// datapath
	logic [DVW-1:0]    dvd_q;
	logic [DW-1:0]     dsr_q;
	logic [CNTW-1:0]   cnt_q;
	logic [AVG_W-1:0]  avg_q;
	logic [15:0]       vg_q;
	logic [WORD_W-1:0] gw_q;
	logic [WORD_W-1:0] dw_q;
	logic              st_q;
	logic              neg_q;
	logic [MANT_W-1:0] mant_q;
	logic [EXP_W-1:0]  exp_q;

	logic              m_valid_q;
	logic [95:0]       out_data_q;
	logic              out_st_q;

	div_cmd_t          dcmd;
	mul_cmd_t          mcmd;
	logic [MANT_W-1:0] quot;
	logic [DW-1:0]     rem;
	logic [PROD_W-1:0] prod;

	gce_sdiv #(.DW(DW)) u_div (
		.clk     (clk),
		.cmd     (dcmd),
		.divisor (dsr_q),
		.quot    (quot),
		.rem     (rem)
	);

	gce_smul u_mul (
		.clk   (clk),
		.cmd   (mcmd),
		.mcand (mant_q),
		.prod  (prod)
	);

	// poll handling
	logic [7:0]    in_cnt;
	logic [15:0]   in_raw;
	logic          accept;
	logic [CW-1:0] taken_nx;
	logic [SW-1:0] sum_nx;
	logic [TW-1:0] target;
	logic          run_done;

	assign in_cnt   = s_axis_tdata[7:0];
	assign in_raw   = s_axis_tdata[23:8];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign taken_nx = taken_q + CW'(1);
	assign sum_nx   = sum_q + SW'(in_raw);

	always_comb begin
		if (sample_count_q == '0)
			target = TW'(1);
		else if (TW'(sample_count_q) > TW'(MAX_SAMPLES))
			target = TW'(MAX_SAMPLES);
		else
			target = TW'(sample_count_q);
	end

	assign run_done = accept && seen_q && (in_cnt != last_q) && (TW'(taken_nx) >= target);

	// current denominator: avg - trunc0((coulomb_offset + board_trim) / 16)
	logic signed [16:0] off_sum;
	logic signed [16:0] off_adj;
	logic signed [16:0] off;
	logic signed [17:0] denom;
	logic [17:0]        denom_mag;

	assign off_sum   = {coff_q[15], coff_q} + {{9{btrim_q[7]}}, btrim_q};
	assign off_adj   = off_sum + (off_sum[16] ? 17'sd15 : 17'sd0);
	assign off       = off_adj >>> 4;
	assign denom     = $signed({2'b00, quot[AVG_W-1:0]}) - $signed({off[16], off});
	assign denom_mag = denom[17] ? 18'(-denom) : 18'(denom);

	// gain rounding
	logic [DW:0]     rem2;
	logic            g_up;
	logic [MANT_W:0] g_rnd;

	assign rem2  = {rem, 1'b0};
	assign g_up  = (rem2 > {1'b0, dsr_q}) || ((rem2 == {1'b0, dsr_q}) && quot[0]);
	assign g_rnd = {1'b0, quot} + (MANT_W+1)'(g_up);

	// delta rounding
	logic              p_top;
	logic [MANT_W-1:0] d_q;
	logic              d_guard;
	logic              d_sticky;
	logic [MANT_W:0]   d_rnd;
	logic [EXP_W-1:0]  d_exp;
	logic [MANT_W-1:0] d_mant;

	assign p_top    = prod[PROD_W-1];
	assign d_q      = p_top ? prod[PROD_W-1:DF_W] : prod[PROD_W-2:DF_W-1];
	assign d_guard  = p_top ? prod[DF_W-1] : prod[DF_W-2];
	assign d_sticky = p_top ? |prod[DF_W-2:0] : |prod[DF_W-3:0];
	assign d_rnd    = {1'b0, d_q} + (MANT_W+1)'(d_guard && (d_sticky || d_q[0]));
	assign d_mant   = d_rnd[MANT_W] ? {1'b1, {(MANT_W-1){1'b0}}} : d_rnd[MANT_W-1:0];
	assign d_exp    = exp_q + (p_top ? EXP_W'(DF_W) : EXP_W'(DF_W - 1))
		+ EXP_W'(d_rnd[MANT_W]);

	logic out_free;
	assign out_free = !m_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (run_done) state_nx = ST_AVG;
			ST_AVG:    if (cnt_q == CNTW'(SW - 1)) state_nx = ST_BRANCH;
			ST_BRANCH: begin
				if (!cal_mode_q)
					state_nx = (quot[AVG_W-1:0] == '0) ? ST_FIN : ST_VDIV;
				else if (denom == '0 || known_q == '0)
					state_nx = ST_FIN;
				else
					state_nx = ST_CDIV;
			end
			ST_VDIV:   if (cnt_q == CNTW'(VDIV_STEPS - 1)) state_nx = ST_VDONE;
			ST_VDONE:  state_nx = ST_FIN;
			ST_CDIV:   if (quot[MANT_W-1]) state_nx = ST_CRND;
			ST_CRND:   state_nx = ST_MUL;
			ST_MUL:    if (cnt_q == CNTW'(DF_W - 1)) state_nx = ST_DRND;
			ST_DRND:   state_nx = ST_FIN;
			ST_FIN:    if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		dcmd          = '0;
		mcmd          = '0;
		dcmd.din      = dvd_q[DVW-1];
		mcmd.cbit     = DELTA_FACTOR[cnt_q[4:0]];
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				dcmd.clear    = 1'b1;
			end
			ST_AVG, ST_VDIV: dcmd.step = 1'b1;
			ST_BRANCH:       dcmd.clear = 1'b1;
			ST_CDIV:         dcmd.step = !quot[MANT_W-1];
			ST_CRND:         mcmd.clear = 1'b1;
			ST_MUL:          mcmd.step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= 9'd16;
			cal_mode_q     <= 1'b0;
			known_q        <= '0;
			coff_q         <= '0;
			btrim_q        <= '0;
			seen_q         <= 1'b0;
			last_q         <= '0;
			sum_q          <= '0;
			taken_q        <= '0;
			cnt_q          <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_SAMPLE_COUNT:   sample_count_q <= cfg_wdata[8:0];
					REG_CAL_MODE:       cal_mode_q     <= cfg_wdata[0];
					REG_KNOWN_VALUE:    known_q        <= cfg_wdata;
					REG_COULOMB_OFFSET: coff_q         <= cfg_wdata;
					REG_BOARD_TRIM:     btrim_q        <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (!seen_q) begin
					seen_q <= 1'b1;
					last_q <= in_cnt;
				end else if (in_cnt != last_q) begin
					last_q <= in_cnt;
					if (run_done) begin
						seen_q  <= 1'b0;
						sum_q   <= '0;
						taken_q <= '0;
					end else begin
						sum_q   <= sum_nx;
						taken_q <= taken_nx;
					end
				end
			end
			unique case (state_q)
				ST_IDLE, ST_BRANCH, ST_CRND: cnt_q <= '0;
				ST_AVG, ST_VDIV, ST_MUL:     cnt_q <= cnt_q + CNTW'(1);
				ST_CDIV: if (!quot[MANT_W-1]) cnt_q <= cnt_q + CNTW'(1);
				default: ;
			endcase
			if (state_q == ST_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (run_done) begin
				dvd_q <= DVW'(sum_nx) << (DVW - SW);
				dsr_q <= DW'(taken_nx);
			end
			ST_AVG, ST_VDIV, ST_CDIV: dvd_q <= {dvd_q[DVW-2:0], 1'b0};
			ST_BRANCH: begin
				avg_q <= quot[AVG_W-1:0];
				vg_q  <= '0;
				gw_q  <= '0;
				dw_q  <= '0;
				st_q  <= 1'b0;
				neg_q <= denom[17];
				if (!cal_mode_q) begin
					st_q  <= (quot[AVG_W-1:0] == '0);
					dvd_q <= DVW'({known_q, 16'h0000}) << (DVW - VDIV_STEPS);
					dsr_q <= DW'(quot[AVG_W-1:0]);
				end else begin
					st_q  <= (denom == '0);
					dvd_q <= DVW'(known_q) << (DVW - KNOWN_W);
					dsr_q <= DW'(denom_mag[16:0]);
				end
			end
			ST_VDONE: vg_q <= quot[15:0];
			ST_CRND: begin
				mant_q <= g_rnd[MANT_W] ? {1'b1, {(MANT_W-1){1'b0}}} : g_rnd[MANT_W-1:0];
				exp_q  <= EXP_W'(GAIN_EXP_BASE) - EXP_W'(cnt_q) + EXP_W'(g_rnd[MANT_W]);
			end
			ST_DRND: begin
				gw_q <= pack_word(neg_q, exp_q, mant_q);
				dw_q <= pack_word(neg_q, d_exp, d_mant);
			end
			ST_FIN: if (out_free) begin
				out_data_q <= {dw_q, gw_q, vg_q, avg_q};
				out_st_q   <= st_q;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_st_q;

`ifndef SYNTHESIS
	a_busy_no_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("poll taken during coefficient pass");
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> mant_q[MANT_W-1])
		else $error("gain mantissa not normalized");
	a_cdiv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CDIV) |-> (cnt_q <= CNTW'(CDIV_MAX)))
		else $error("gain division ran too long");
	a_drnd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRND) |-> ($past(state_q) == ST_MUL))
		else $error("delta rounding without multiply");
`endif

endmodule

// ----- rtl/gce_sdiv.sv -----
module gce_sdiv import gce_pkg::*; #(
	parameter int DW = 17
) (
	input  logic              clk,
	input  div_cmd_t          cmd,
	input  logic [DW-1:0]     divisor,
	output logic [MANT_W-1:0] quot,
	output logic [DW-1:0]     rem
);

	logic [DW-1:0]     rem_q;
	logic [MANT_W-1:0] quot_q;
	logic [DW:0]       trial;
	logic              ge;
	logic [DW:0]       diff;

	assign trial = {rem_q, cmd.din};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			rem_q  <= '0;
			quot_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quot_q <= {quot_q[MANT_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/gce_smul.sv -----
module gce_smul import gce_pkg::*; (
	input  logic              clk,
	input  mul_cmd_t          cmd,
	input  logic [MANT_W-1:0] mcand,
	output logic [PROD_W-1:0] prod
);

	logic [MANT_W-1:0] hi_q;
	logic [DF_W-1:0]   lo_q;
	logic [MANT_W:0]   sum;

	assign sum = {1'b0, hi_q} + (cmd.cbit ? {1'b0, mcand} : '0);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (cmd.step) begin
			hi_q <= sum[MANT_W:1];
			lo_q <= {sum[0], lo_q[DF_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

endmodule
